@@ src/lfsht_pkg.sv @@
// Shared types and constants for the lowest-free-slot handle table.
package lfsht_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int SLOT_W    = 8;
  localparam int HANDLE_W  = 32;
  localparam int OP_W      = 3;
  localparam int CHUNK_SH  = 5;
  localparam int CHUNK_W   = 1 << CHUNK_SH;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_GET       = 3'd1,
    OP_CLOSE     = 3'd2,
    OP_ALLOC_AT  = 3'd3,
    OP_CLOSE_ALL = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ACCESS,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_t;

endpackage

@@ src/lowest_free_slot_handle_table_unit.sv @@
// Handle table with lowest-free-slot allocation, one request at a time.
//
// Handles live in a SLOTS-entry synchronous memory; an occupancy bitmap in flip-flops marks
// the slots in use and is cleared by reset, so the table is empty right after reset with no
// clearing pass. Requests are taken one at a time. Get, close and alloc-at go from acceptance
// to a loaded result through the accept, memory read and respond steps. Alloc searches the
// 32-slot bitmap words in turn, starting at the word that holds lowest_slot. Close-all walks
// the bitmap one slot a cycle while scanning and, for each occupied slot, adds a step for the
// memory read and result, which waits while the result side stalls. A result waits in an
// output register while the next request is taken; a stall on the result side holds the
// block only when it has a new result to load.
module lowest_free_slot_handle_table_unit #(
  parameter int SLOTS = lfsht_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [lfsht_pkg::OP_W-1:0]     opcode,
  input  logic [lfsht_pkg::SLOT_W-1:0]   slot_index,
  input  logic [lfsht_pkg::SLOT_W-1:0]   lowest_slot,
  input  logic [lfsht_pkg::HANDLE_W-1:0] handle_in,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          status,
  output logic [lfsht_pkg::SLOT_W-1:0]   slot_out,
  output logic [lfsht_pkg::HANDLE_W-1:0] handle_out,
  output logic                          last
);

  localparam int SLOT_W   = lfsht_pkg::SLOT_W;
  localparam int HANDLE_W = lfsht_pkg::HANDLE_W;
  localparam int OP_W     = lfsht_pkg::OP_W;
  localparam int CHUNK_W  = lfsht_pkg::CHUNK_W;
  localparam int CHUNK_SH = lfsht_pkg::CHUNK_SH;
  localparam int ADDR_W   = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int NCHUNK   = (SLOTS + CHUNK_W - 1) / CHUNK_W;
  localparam int CIW      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int FW       = CIW + CHUNK_SH;
  localparam logic [SLOT_W:0] SLOTS_LIM = (SLOT_W + 1)'(SLOTS);
  localparam logic [CIW-1:0]  LAST_CHUNK = CIW'(NCHUNK - 1);

  lfsht_pkg::state_t state, state_next;

  logic [OP_W-1:0]     req_op, req_op_next;
  logic [SLOT_W-1:0]   req_idx, req_idx_next;
  logic [SLOT_W-1:0]   req_low, req_low_next;
  logic [HANDLE_W-1:0] req_handle, req_handle_next;
  logic [CIW-1:0]      chunk, chunk_next;
  logic [ADDR_W-1:0]   ptr, ptr_next;
  logic [SLOTS-1:0]    occ, occ_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                res_status, res_status_next;
  logic [SLOT_W-1:0]   res_slot, res_slot_next;
  logic [HANDLE_W-1:0] res_handle, res_handle_next;

  logic                rsp_load;
  logic                load_status;
  logic [SLOT_W-1:0]   load_slot;
  logic [HANDLE_W-1:0] load_handle;
  logic                load_last;
  logic                out_free;

  logic [HANDLE_W-1:0] mem [SLOTS];
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [HANDLE_W-1:0] wr_data, rd_data;

  logic [NCHUNK*CHUNK_W-1:0] occ_pad;
  logic [CHUNK_W-1:0]        chunk_free;
  logic [CHUNK_SH-1:0]       free_pos;
  logic [FW-1:0]             found_cat;
  logic [CIW-1:0]            low_chunk;
  logic [CHUNK_SH-1:0]       low_off;
  logic                      in_range;
  logic [ADDR_W-1:0]         acc_addr;
  logic [HANDLE_W-1:0]       acc_old;

  assign req_stall = (state != lfsht_pkg::ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign in_range  = ({1'b0, slot_index} < SLOTS_LIM);
  assign acc_addr  = req_idx[ADDR_W-1:0];
  assign acc_old   = occ[acc_addr] ? rd_data : '0;
  assign low_chunk = CIW'(req_low >> CHUNK_SH);
  assign low_off   = req_low[CHUNK_SH-1:0];
  assign found_cat = {chunk, free_pos};

  always_comb begin
    occ_pad = '1;
    occ_pad[SLOTS-1:0] = occ;
    for (int b = 0; b < CHUNK_W; b++) begin
      chunk_free[b] = !occ_pad[chunk*CHUNK_W + b] &&
                      !((chunk == low_chunk) && (CHUNK_SH'(b) < low_off));
    end
    free_pos = '0;
    for (int b = CHUNK_W - 1; b >= 0; b--) begin
      if (chunk_free[b]) begin
        free_pos = CHUNK_SH'(b);
      end
    end
  end

  always_comb begin
    state_next      = state;
    req_op_next     = req_op;
    req_idx_next    = req_idx;
    req_low_next    = req_low;
    req_handle_next = req_handle;
    chunk_next      = chunk;
    ptr_next        = ptr;
    occ_next        = occ;
    count_next      = count;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_handle_next = res_handle;
    rsp_load        = 1'b0;
    load_status     = res_status;
    load_slot       = res_slot;
    load_handle     = res_handle;
    load_last       = 1'b1;
    wr_en           = 1'b0;
    wr_addr         = acc_addr;
    wr_data         = req_handle;
    rd_en           = 1'b0;
    rd_addr         = ADDR_W'(slot_index);

    unique case (state)
      lfsht_pkg::ST_IDLE: begin
        if (req_valid) begin
          req_op_next     = opcode;
          req_idx_next    = slot_index;
          req_low_next    = lowest_slot;
          req_handle_next = handle_in;
          res_status_next = 1'b1;
          res_slot_next   = slot_index;
          res_handle_next = '0;
          state_next      = lfsht_pkg::ST_RESP;
          unique case (opcode) inside
            lfsht_pkg::OP_ALLOC: begin
              res_slot_next = '0;
              if ({1'b0, lowest_slot} < SLOTS_LIM) begin
                chunk_next = CIW'(lowest_slot >> CHUNK_SH);
                state_next = lfsht_pkg::ST_SEARCH;
              end
            end
            lfsht_pkg::OP_GET, lfsht_pkg::OP_CLOSE: begin
              if (in_range) begin
                rd_en      = 1'b1;
                state_next = lfsht_pkg::ST_ACCESS;
              end
            end
            lfsht_pkg::OP_ALLOC_AT: begin
              if (in_range && (handle_in != '0)) begin
                rd_en      = 1'b1;
                state_next = lfsht_pkg::ST_ACCESS;
              end
            end
            lfsht_pkg::OP_CLOSE_ALL: begin
              res_slot_next = '0;
              if (count == '0) begin
                res_status_next = 1'b0;
              end else begin
                ptr_next   = '0;
                state_next = lfsht_pkg::ST_SCAN;
              end
            end
            default: begin
              res_slot_next = '0;
            end
          endcase
        end
      end

      lfsht_pkg::ST_SEARCH: begin
        if (|chunk_free) begin
          wr_en           = 1'b1;
          wr_addr         = ADDR_W'(found_cat);
          occ_next[ADDR_W'(found_cat)] = (req_handle != '0);
          if (req_handle != '0) begin
            count_next = count + CNT_W'(1);
          end
          res_status_next = 1'b0;
          res_slot_next   = SLOT_W'(found_cat);
          state_next      = lfsht_pkg::ST_RESP;
        end else if (chunk == LAST_CHUNK) begin
          state_next = lfsht_pkg::ST_RESP;
        end else begin
          chunk_next = chunk + CIW'(1);
        end
      end

      lfsht_pkg::ST_ACCESS: begin
        state_next = lfsht_pkg::ST_RESP;
        case (req_op)
          lfsht_pkg::OP_GET: begin
            res_status_next = 1'b0;
            res_handle_next = acc_old;
          end
          lfsht_pkg::OP_CLOSE: begin
            if (occ[acc_addr]) begin
              occ_next[acc_addr] = 1'b0;
              count_next         = count - CNT_W'(1);
              res_status_next    = 1'b0;
              res_handle_next    = acc_old;
            end
          end
          default: begin
            wr_en              = 1'b1;
            occ_next[acc_addr] = 1'b1;
            if (!occ[acc_addr]) begin
              count_next = count + CNT_W'(1);
            end
            res_status_next = 1'b0;
            res_handle_next = acc_old;
          end
        endcase
      end

      lfsht_pkg::ST_SCAN: begin
        rd_addr = ptr;
        if (occ[ptr]) begin
          rd_en      = 1'b1;
          state_next = lfsht_pkg::ST_DRAIN;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end

      lfsht_pkg::ST_DRAIN: begin
        if (out_free) begin
          rsp_load      = 1'b1;
          load_status   = 1'b0;
          load_slot     = SLOT_W'(ptr);
          load_handle   = rd_data;
          load_last     = (count == CNT_W'(1));
          occ_next[ptr] = 1'b0;
          count_next    = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next = lfsht_pkg::ST_IDLE;
          end else begin
            ptr_next   = ptr + ADDR_W'(1);
            state_next = lfsht_pkg::ST_SCAN;
          end
        end
      end

      lfsht_pkg::ST_RESP: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = lfsht_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lfsht_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfsht_pkg::ST_IDLE;
      occ       <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_op     <= req_op_next;
    req_idx    <= req_idx_next;
    req_low    <= req_low_next;
    req_handle <= req_handle_next;
    chunk      <= chunk_next;
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_handle <= res_handle_next;
    if (rsp_load) begin
      status     <= load_status;
      slot_out   <= load_slot;
      handle_out <= load_handle;
      last       <= load_last;
    end
  end

endmodule
